>>> design/glyph_quad_text_layout_macros.svh
// Assertion helpers for the text layout block.
// The SYNTH flavour drops every check.
`ifndef GLYPH_QUAD_TEXT_LAYOUT_MACROS_SVH
`define GLYPH_QUAD_TEXT_LAYOUT_MACROS_SVH
`ifndef SYNTH
`define GQTL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define GQTL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define GQTL_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define GQTL_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

>>> design/gqtl_pkg.sv
package gqtl_pkg;

   localparam int PEN_BITS = 16;
   localparam int POS_BITS = 16;
   localparam int CNT_BITS = 16;
   localparam int CODE_BITS = 8;
   localparam int ADV_BITS = 3;
   localparam int TEX_BITS = 5;
   localparam int VTX_BITS = 4;
   localparam int CORNER_BITS = 3;
   localparam int OFS_BITS = 4;

   typedef logic [PEN_BITS-1:0] pen_type;
   typedef logic [POS_BITS-1:0] pos_type;
   typedef logic [CNT_BITS-1:0] cnt_type;
   typedef logic [CODE_BITS-1:0] code_type;
   typedef logic [ADV_BITS-1:0] adv_type;
   typedef logic [VTX_BITS-1:0] vtx_type;
   typedef logic [CORNER_BITS-1:0] corner_type;

   localparam code_type CODE_NEWLINE = 8'd10;
   localparam code_type CODE_SPACE = 8'd32;

   localparam pen_type LINE_STEP = PEN_BITS'(9);
   localparam pen_type SPACE_STEP = PEN_BITS'(4);

   localparam vtx_type VTX_FIRST = 4'd0;
   localparam vtx_type VTX_QUAD = 4'd6;
   localparam vtx_type VTX_LAST = 4'd11;

   // Pen advance after a glyph; most codes take six pixels.
   function automatic adv_type glyph_advance(input code_type code);
      adv_type adv;
      unique case (code)
         8'd33, 8'd44, 8'd46, 8'd105: adv = 3'd2;
         8'd39, 8'd108:               adv = 3'd3;
         8'd73, 8'd116:               adv = 3'd4;
         8'd34, 8'd40, 8'd41, 8'd42,
         8'd102, 8'd107:              adv = 3'd5;
         8'd64:                       adv = 3'd7;
         default:                     adv = 3'd6;
      endcase
      return adv;
   endfunction

   // Corner tables over the six vertices of a quad.
   function automatic logic [OFS_BITS-1:0] corner_x(input corner_type j);
      logic [OFS_BITS-1:0] ofs;
      unique case (j)
         3'd1, 3'd2, 3'd3: ofs = 4'd8;
         default:          ofs = 4'd0;
      endcase
      return ofs;
   endfunction

   function automatic logic [OFS_BITS-1:0] corner_y(input corner_type j);
      logic [OFS_BITS-1:0] ofs;
      unique case (j)
         3'd2, 3'd3, 3'd4: ofs = 4'd8;
         default:          ofs = 4'd0;
      endcase
      return ofs;
   endfunction

   function automatic logic corner_u(input corner_type j);
      logic ofs;
      unique case (j)
         3'd1, 3'd2, 3'd3: ofs = 1'b1;
         default:          ofs = 1'b0;
      endcase
      return ofs;
   endfunction

   function automatic logic corner_v(input corner_type j);
      logic ofs;
      unique case (j)
         3'd0, 3'd1, 3'd5: ofs = 1'b1;
         default:          ofs = 1'b0;
      endcase
      return ofs;
   endfunction

   // Read the pen as signed and wrap it to vertex width.
   function automatic pos_type pen_to_pos(input pen_type pen);
      logic signed [31:0] wide;
      wide = 32'($signed(pen));
      return wide[POS_BITS-1:0];
   endfunction

endpackage

>>> design/gqtl_adv_rom.sv
module gqtl_adv_rom (
   input  logic                clock,
   input  logic                rd_en,
   input  gqtl_pkg::code_type  rd_addr,
   output gqtl_pkg::adv_type   rd_data
);
   import gqtl_pkg::*;

   adv_type data_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         data_ff <= glyph_advance(rd_addr);
      end
   end

   assign rd_data = data_ff;

endmodule

>>> design/glyph_quad_text_layout.sv
// Text layout: one character code per request, up to twelve vertex responses out.
// A printable code occupies the block until its twelfth vertex is sent, one vertex
// leaving the response register per cycle while it is not stalled; the next request
// is taken in the cycle that sends the twelfth vertex. Newline and space produce no
// vertices and are taken at one per cycle. The pen advance comes from a
// 256-entry registered ROM read when the request is taken; it is applied to the pen as
// the twelfth vertex goes out. Response stall holds the vertex sequencer in place.
`include "glyph_quad_text_layout_macros.svh"

module glyph_quad_text_layout (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  gqtl_pkg::code_type         req_char_code,
   input  logic                       req_start_of_text,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [15:0]         rsp_pos_x,
   output logic signed [15:0]         rsp_pos_y,
   output logic [4:0]                 rsp_tex_u,
   output logic [4:0]                 rsp_tex_v,
   output logic                       rsp_is_shadow,
   output logic [15:0]                rsp_vertex_number,
   output logic                       rsp_last_of_run
);
   import gqtl_pkg::*;

   pen_type    pen_x_ff, pen_x_in;
   pen_type    pen_y_ff, pen_y_in;
   cnt_type    cnt_ff, cnt_in;
   logic       busy_ff, busy_in;
   vtx_type    vtx_ff, vtx_in;
   code_type   code_ff, code_in;
   adv_type    adv;

   logic       rsp_valid_ff;
   pos_type    rsp_pos_x_ff, rsp_pos_y_ff;
   logic [TEX_BITS-1:0] rsp_tex_u_ff, rsp_tex_v_ff;
   logic       rsp_shadow_ff;
   cnt_type    rsp_number_ff;
   logic       rsp_last_ff;

   logic       slot_free, emit, finish, req_fire, req_printable;
   logic       shadow;
   corner_type corner;
   pos_type    base_x, base_y, vtx_x, vtx_y;
   logic [TEX_BITS-1:0] vtx_u, vtx_v;

   gqtl_adv_rom u_adv_rom (
      .clock   (clock),
      .rd_en   (req_fire),
      .rd_addr (req_char_code),
      .rd_data (adv)
   );

   assign slot_free     = !rsp_valid_ff || !rsp_stall;
   assign emit          = busy_ff && slot_free;
   assign finish        = emit && (vtx_ff == VTX_LAST);
   assign req_stall     = busy_ff && !finish;
   assign req_fire      = req_valid && !req_stall;
   assign req_printable = (req_char_code != CODE_NEWLINE) && (req_char_code != CODE_SPACE);

   always_comb begin
      // retire the current glyph first, then apply the incoming request
      pen_x_in = finish ? pen_x_ff + PEN_BITS'(adv) : pen_x_ff;
      pen_y_in = pen_y_ff;
      cnt_in   = emit ? cnt_ff + 1'b1 : cnt_ff;
      busy_in  = finish ? 1'b0 : busy_ff;
      vtx_in   = emit ? vtx_ff + 1'b1 : vtx_ff;
      code_in  = code_ff;
      if (req_fire) begin
         if (req_start_of_text) begin
            pen_x_in = '0;
            pen_y_in = '0;
            cnt_in   = '0;
         end
         priority if (req_char_code == CODE_NEWLINE) begin
            pen_x_in = '0;
            pen_y_in = pen_y_in - LINE_STEP;
         end else if (req_char_code == CODE_SPACE) begin
            pen_x_in = pen_x_in + SPACE_STEP;
         end else begin
            busy_in = 1'b1;
         end
         vtx_in  = VTX_FIRST;
         code_in = req_char_code;
      end
   end

   always_comb begin
      shadow = vtx_ff < VTX_QUAD;
      corner = shadow ? vtx_ff[CORNER_BITS-1:0] : CORNER_BITS'(vtx_ff - VTX_QUAD);
      base_x = pen_to_pos(pen_x_ff) + POS_BITS'(shadow);
      base_y = pen_to_pos(pen_y_ff) - POS_BITS'(shadow);
      vtx_x  = base_x + POS_BITS'(corner_x(corner));
      vtx_y  = base_y + POS_BITS'(corner_y(corner));
      vtx_u  = TEX_BITS'(code_ff[3:0]) + TEX_BITS'(corner_u(corner));
      vtx_v  = TEX_BITS'(code_ff[7:4]) + TEX_BITS'(corner_v(corner));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pen_x_ff <= '0;
         pen_y_ff <= '0;
         cnt_ff   <= '0;
         busy_ff  <= 1'b0;
         vtx_ff   <= VTX_FIRST;
      end else begin
         pen_x_ff <= pen_x_in;
         pen_y_ff <= pen_y_in;
         cnt_ff   <= cnt_in;
         busy_ff  <= busy_in;
         vtx_ff   <= vtx_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff <= code_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_pos_x_ff  <= vtx_x;
         rsp_pos_y_ff  <= vtx_y;
         rsp_tex_u_ff  <= vtx_u;
         rsp_tex_v_ff  <= vtx_v;
         rsp_shadow_ff <= shadow;
         rsp_number_ff <= cnt_ff + 1'b1;
         rsp_last_ff   <= (vtx_ff == VTX_LAST);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pos_x         = rsp_pos_x_ff;
   assign rsp_pos_y         = rsp_pos_y_ff;
   assign rsp_tex_u         = rsp_tex_u_ff;
   assign rsp_tex_v         = rsp_tex_v_ff;
   assign rsp_is_shadow     = rsp_shadow_ff;
   assign rsp_vertex_number = rsp_number_ff;
   assign rsp_last_of_run   = rsp_last_ff;

   `GQTL_ASSERT_NEXT(a_glyph_starts, clock, reset, req_fire && req_printable,
      busy_ff && (vtx_ff == VTX_FIRST), "glyph request did not start the vertex sequence")
   `GQTL_ASSERT_NEXT(a_pen_hold, clock, reset, busy_ff && !finish,
      $stable(pen_x_ff) && $stable(pen_y_ff), "pen moved in the middle of a glyph")
   `GQTL_ASSERT_NEXT(a_last_marked, clock, reset, finish,
      rsp_valid_ff && rsp_last_ff && !rsp_shadow_ff, "twelfth vertex not marked as last")
   `GQTL_ASSERT_NOW(a_take_on_finish, clock, reset, req_fire && busy_ff,
      finish, "request taken while a glyph was still running")

endmodule
